// ===== sv/plsl_pkg.sv =====
`timescale 1ns / 1ps

package plsl_pkg;

    // Fixed widths of the register and result fields
    localparam int LVL_W      = 4;
    localparam int HL_W       = LVL_W + 1;
    localparam int OUT_CH     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Defaults of the top-level parameters
    localparam int DEF_CHANNELS       = 3;
    localparam int DEF_LEVELS         = 10;
    localparam int DEF_TICKS_PER_STEP = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOCK_ENABLE = 2'd0,
        REG_TARGET_CH0  = 2'd1,
        REG_TARGET_CH1  = 2'd2,
        REG_TARGET_CH2  = 2'd3
    } plsl_reg_idx_t;

    typedef struct packed {
        logic             pin;
        logic [LVL_W-1:0] level;
    } plsl_chan_res_t;

    typedef struct packed {
        logic             lock_en;
        logic [LVL_W-1:0] target;
    } plsl_lock_t;

endpackage

// ===== sv/pwm_level_sweep_lock_top.sv =====
`timescale 1ns / 1ps

// Sweeping-duty PWM generator. Each poll beat on the tick channel produces one
// result beat with the pin level and duty level of channels 0 to 2. A poll is
// taken into an input register, and its result is loaded into the result
// register as soon as that register is free. One poll can be accepted every
// cycle while tick stall is low. The per-channel counter compare lies
// between those two registers. Tick stall is raised only while a finished
// result is waiting and the downstream side is stalling. Configuration
// writes are always ready and should be issued while no poll is in flight.
module pwm_level_sweep_lock_top #(
    parameter int CHANNELS       = plsl_pkg::DEF_CHANNELS,
    parameter int LEVELS         = plsl_pkg::DEF_LEVELS,
    parameter int TICKS_PER_STEP = plsl_pkg::DEF_TICKS_PER_STEP
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tick_valid,
    output logic                            tick_stall,
    input  logic                            tick,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            pin_ch0,
    output logic                            pin_ch1,
    output logic                            pin_ch2,
    output logic [plsl_pkg::LVL_W-1:0]      level_ch0,
    output logic [plsl_pkg::LVL_W-1:0]      level_ch1,
    output logic [plsl_pkg::LVL_W-1:0]      level_ch2,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [plsl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plsl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import plsl_pkg::*;

    logic             lock_reg;
    logic [LVL_W-1:0] target_reg [OUT_CH];

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_tick_reg;
    logic             out_valid_reg, out_valid_next;
    logic             res_free;
    logic             advance;

    plsl_chan_res_t   chan_res  [CHANNELS];
    plsl_chan_res_t   res_reg   [OUT_CH];
    plsl_chan_res_t   res_next  [OUT_CH];

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_reg <= 1'b0;
            for (int i = 0; i < OUT_CH; i++)
            begin
                target_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (plsl_reg_idx_t'(cfg_index))
                REG_LOCK_ENABLE: lock_reg      <= cfg_data[0];
                REG_TARGET_CH0:  target_reg[0] <= cfg_data[LVL_W-1:0];
                REG_TARGET_CH1:  target_reg[1] <= cfg_data[LVL_W-1:0];
                REG_TARGET_CH2:  target_reg[2] <= cfg_data[LVL_W-1:0];
                default:         lock_reg      <= lock_reg;
            endcase
        end
    end

    // The result register is free when empty or being taken this cycle.
    assign res_free   = !out_valid_reg || !result_stall;
    assign advance    = s1_valid_reg && res_free;
    assign tick_stall = s1_valid_reg && !res_free;

    assign s1_valid_next  = tick_stall ? s1_valid_reg : tick_valid;
    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!tick_stall && tick_valid)
        begin
            s1_tick_reg <= tick;
        end
    end

    // Channel datapaths; only the first three channels have lock targets.
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        plsl_lock_t lock;
        if (c < OUT_CH)
        begin : g_lock
            assign lock.lock_en = lock_reg;
            assign lock.target  = target_reg[c];
        end
        else
        begin : g_nolock
            assign lock.lock_en = 1'b0;
            assign lock.target  = '0;
        end

        plsl_channel #(
            .LEVELS         (LEVELS),
            .TICKS_PER_STEP (TICKS_PER_STEP)
        ) u_chan (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tick    (s1_tick_reg),
            .lock    (lock),
            .res     (chan_res[c])
        );
    end

    for (genvar c = 0; c < OUT_CH; c++)
    begin : g_res
        if (c < CHANNELS)
        begin : g_used
            assign res_next[c] = chan_res[c];
        end
        else
        begin : g_unused
            assign res_next[c] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < OUT_CH; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign pin_ch0      = res_reg[0].pin;
    assign pin_ch1      = res_reg[1].pin;
    assign pin_ch2      = res_reg[2].pin;
    assign level_ch0    = res_reg[0].level;
    assign level_ch1    = res_reg[1].level;
    assign level_ch2    = res_reg[2].level;

    // A poll that moves on always leaves a result behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
    else $error("poll advanced without producing a result");

    // The tick side stalls only behind a held result and an occupied input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> (result_valid && result_stall && s1_valid_reg))
    else $error("tick stall raised without back-pressure");

    // Reported duty levels stay within range.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((level_ch0 < LEVELS) && (level_ch1 < LEVELS)
                          && (level_ch2 < LEVELS)))
    else $error("duty level out of range");

endmodule

// ===== sv/plsl_channel.sv =====
`timescale 1ns / 1ps

module plsl_channel #(
    parameter int LEVELS         = plsl_pkg::DEF_LEVELS,
    parameter int TICKS_PER_STEP = plsl_pkg::DEF_TICKS_PER_STEP
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     tick,
    input  plsl_pkg::plsl_lock_t     lock,
    output plsl_pkg::plsl_chan_res_t res
);
    import plsl_pkg::*;

    localparam int CAP   = LEVELS * TICKS_PER_STEP;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP);
    localparam logic [CNT_W-1:0] TPS_C = CNT_W'(TICKS_PER_STEP);

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_LOW   = 2'd1,
        PH_HIGH  = 2'd2
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [LVL_W-1:0] level_reg, level_next;
    logic [LVL_W-1:0] low_len_reg, low_len_next;
    logic [HL_W-1:0]  high_len_reg, high_len_next;
    logic [CNT_W-1:0] low_lim, high_lim;
    logic [HL_W-1:0]  level_up;
    logic             held;
    logic             pin;

    assign cnt_inc  = (tick && (cnt_reg < CAP_C)) ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign low_lim  = CNT_W'(CNT_W'(low_len_reg) * TPS_C);
    assign high_lim = CNT_W'(CNT_W'(high_len_reg) * TPS_C);
    assign level_up = HL_W'(level_reg) + HL_W'(1);
    // A target at or above LEVELS can never equal a level, so it never holds.
    assign held     = lock.lock_en && (lock.target == level_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_inc;
        level_next    = level_reg;
        low_len_next  = low_len_reg;
        high_len_next = high_len_reg;
        pin           = 1'b0;
        case (phase_reg)
            PH_LOW:
            begin
                if (cnt_inc >= low_lim)
                begin
                    cnt_next      = '0;
                    high_len_next = level_up;
                    phase_next    = PH_HIGH;
                    pin           = 1'b1;
                end
            end
            PH_HIGH:
            begin
                pin = 1'b1;
                if (cnt_inc >= high_lim)
                begin
                    if (!held)
                    begin
                        level_next = (level_up >= HL_W'(LEVELS)) ? '0 : level_up[LVL_W-1:0];
                    end
                    phase_next = PH_START;
                    pin        = 1'b0;
                end
            end
            default:
            begin
                low_len_next = LVL_W'(LEVELS - 1) - level_reg;
                cnt_next     = '0;
                phase_next   = PH_LOW;
            end
        endcase
    end

    assign res.pin   = pin;
    assign res.level = level_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            cnt_reg      <= '0;
            level_reg    <= '0;
            low_len_reg  <= '0;
            high_len_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            level_reg    <= level_next;
            low_len_reg  <= low_len_next;
            high_len_reg <= high_len_next;
        end
    end

endmodule
